// File: hdl/drru_pkg.sv
`default_nettype none
package drru_pkg;

	typedef enum logic [1:0] {
		KIND_UNION  = 2'd0,
		KIND_READ   = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_REJECT   = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_UNCUT    = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_READ_WAIT,
		S_READ_DONE,
		S_REMOVE_RD,
		S_REMOVE_WAIT,
		S_PIECE_RD,
		S_PIECE_WAIT,
		S_SCAN_RD,
		S_SCAN_WAIT,
		S_SCAN_EVAL,
		S_DROP_RD,
		S_DROP_WAIT,
		S_DROP_WR,
		S_KEEP,
		S_NEXT_PIECE,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// File: hdl/dirty_rectangle_region_union_core.sv
// Throughput: one request at a time; busy stays high until the result strobe.
//   The single-port read of the rectangle table sets the scan rate.
// Reset: arst_n clears count, extents and control; table and work list hold
//   no reset value and are only read below their fill counts.
`default_nettype none
module dirty_rectangle_region_union_core #(
	parameter int MAX_RECTS  = 64,
	parameter int WORK_DEPTH = 16,
	parameter int COORD_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   kind,
	input  wire logic signed [COORD_BITS-1:0] rect_min_x,
	input  wire logic signed [COORD_BITS-1:0] rect_min_y,
	input  wire logic signed [COORD_BITS-1:0] rect_max_x,
	input  wire logic signed [COORD_BITS-1:0] rect_max_y,
	input  wire logic signed [COORD_BITS-1:0] clip_min_x,
	input  wire logic signed [COORD_BITS-1:0] clip_min_y,
	input  wire logic signed [COORD_BITS-1:0] clip_max_x,
	input  wire logic signed [COORD_BITS-1:0] clip_max_y,
	input  wire logic [$clog2(MAX_RECTS)-1:0] entry_index,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [$clog2(MAX_RECTS+1)-1:0]    rect_count,
	output logic signed [COORD_BITS-1:0]      entry_min_x,
	output logic signed [COORD_BITS-1:0]      entry_min_y,
	output logic signed [COORD_BITS-1:0]      entry_max_x,
	output logic signed [COORD_BITS-1:0]      entry_max_y,
	output logic signed [COORD_BITS-1:0]      bound_min_x,
	output logic signed [COORD_BITS-1:0]      bound_min_y,
	output logic signed [COORD_BITS-1:0]      bound_max_x,
	output logic signed [COORD_BITS-1:0]      bound_max_y
);
	import drru_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int RW = 4 * CB;
	localparam int IW = $clog2(MAX_RECTS);
	localparam int CW = $clog2(MAX_RECTS + 1);
	localparam int WI = $clog2(WORK_DEPTH);
	localparam int WC = $clog2(WORK_DEPTH + 1);

	typedef struct packed {
		logic signed [CB-1:0] x0;
		logic signed [CB-1:0] y0;
		logic signed [CB-1:0] x1;
		logic signed [CB-1:0] y1;
	} box_t;

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	box_t ext_q, ext_d;
	logic [WC-1:0] wcnt_q, wcnt_d;
	logic [WC-1:0] wj_q, wj_d;
	logic [CW-1:0] i_q, i_d;
	box_t p_q, p_d;
	box_t rd_q, rd_d;
	logic [1:0] st_q, st_d;
	logic [IW-1:0] hole_q, hole_d;
	logic keep_q, keep_d;
	logic done_q, done_d;

	// table memory
	logic t_we;
	logic [IW-1:0] t_waddr, t_raddr;
	box_t t_wdata, t_rdata;
	logic [RW-1:0] t_rraw;
	// work memory
	logic w_we;
	logic [WI-1:0] w_waddr, w_raddr;
	box_t w_wdata, w_rdata;
	logic [RW-1:0] w_rraw;

	drru_ram #(.WIDTH(RW), .DEPTH(MAX_RECTS)) u_table (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rraw)
	);
	drru_ram #(.WIDTH(RW), .DEPTH(WORK_DEPTH)) u_work (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rraw)
	);
	assign t_rdata = box_t'(t_rraw);
	assign w_rdata = box_t'(w_rraw);

	function automatic logic f_touch(box_t a, box_t b);
		return a.x0 <= b.x1 && b.x0 <= a.x1 && a.y0 <= b.y1 && b.y0 <= a.y1;
	endfunction
	function automatic logic f_over(box_t a, box_t b);
		return a.x0 < b.x1 && b.x0 < a.x1 && a.y0 < b.y1 && b.y0 < a.y1;
	endfunction
	function automatic logic f_within(box_t a, box_t b);
		return b.x0 <= a.x0 && a.x1 <= b.x1 && b.y0 <= a.y0 && a.y1 <= b.y1;
	endfunction
	function automatic box_t f_clip(box_t a, box_t b);
		box_t r;
		r = a;
		if (a.x0 < b.x0) r.x0 = b.x0;
		if (a.y0 < b.y0) r.y0 = b.y0;
		if (a.x1 > b.x1) r.x1 = b.x1;
		if (a.y1 > b.y1) r.y1 = b.y1;
		return r;
	endfunction
	function automatic box_t f_grow(box_t a, box_t b);
		box_t r;
		r = a;
		if (a.x0 > b.x0) r.x0 = b.x0;
		if (a.y0 > b.y0) r.y0 = b.y0;
		if (a.x1 < b.x1) r.x1 = b.x1;
		if (a.y1 < b.y1) r.y1 = b.y1;
		return r;
	endfunction
	// edge cut: ok flag and result
	function automatic logic [RW:0] f_edge(box_t n, box_t s);
		box_t r;
		logic ok;
		r = n;
		ok = 1'b0;
		if (n.y0 == s.y0 && n.y1 == s.y1 && n.x0 == s.x0) begin
			r.x0 = s.x1; ok = 1'b1;
		end else if (n.y0 == s.y0 && n.y1 == s.y1 && n.x1 == s.x1) begin
			r.x1 = s.x0; ok = 1'b1;
		end else if (n.x0 == s.x0 && n.x1 == s.x1 && n.y0 == s.y0) begin
			r.y0 = s.y1; ok = 1'b1;
		end else if (n.x0 == s.x0 && n.x1 == s.x1 && n.y1 == s.y1) begin
			r.y1 = s.y0; ok = 1'b1;
		end
		return {ok, r};
	endfunction

	box_t in_r, in_c, clipped;
	logic in_ok;
	always_comb begin
		in_r = '{rect_min_x, rect_min_y, rect_max_x, rect_max_y};
		in_c = '{clip_min_x, clip_min_y, clip_max_x, clip_max_y};
		clipped = f_clip(in_r, in_c);
		in_ok = in_r.x0 < in_r.x1 && in_r.y0 < in_r.y1 && f_over(in_r, in_c)
			&& clipped.x0 < clipped.x1 && clipped.y0 < clipped.y1;
	end

	// scan evaluation of entry e against piece p
	box_t e, x, n_cut, o_cut;
	logic [RW:0] ep, ee;
	logic cut_ok;
	always_comb begin
		e = t_rdata;
		x = f_clip(e, p_q);
		ep = f_edge(p_q, x);
		ee = f_edge(e, x);
		n_cut = p_q;
		o_cut = p_q;
		cut_ok = 1'b0;
		if (p_q.x0 == x.x0 && p_q.x1 == x.x1 && p_q.y0 < x.y0 && x.y1 < p_q.y1) begin
			n_cut.y1 = x.y0; o_cut.y0 = x.y1; cut_ok = 1'b1;
		end else if (p_q.y0 == x.y0 && p_q.y1 == x.y1 && p_q.x0 < x.x0
				&& x.x1 < p_q.x1) begin
			n_cut.x1 = x.x0; o_cut.x0 = x.x1; cut_ok = 1'b1;
		end else if (x.x0 == p_q.x0 && x.y0 == p_q.y0) begin
			o_cut = '{x.x1, x.y0, p_q.x1, p_q.y1};
			n_cut = '{x.x0, x.y1, x.x1, p_q.y1}; cut_ok = 1'b1;
		end else if (x.x0 == p_q.x0 && x.y1 == p_q.y1) begin
			o_cut = '{x.x1, p_q.y0, p_q.x1, p_q.y1};
			n_cut = '{p_q.x0, p_q.y0, x.x1, x.y0}; cut_ok = 1'b1;
		end else if (x.x1 == p_q.x1 && x.y1 == p_q.y1) begin
			o_cut = '{x.x0, p_q.y0, x.x1, x.y0};
			n_cut = '{p_q.x0, p_q.y0, x.x0, p_q.y1}; cut_ok = 1'b1;
		end else if (x.x1 == p_q.x1 && x.y0 == p_q.y0) begin
			o_cut = '{x.x0, x.y1, p_q.x1, p_q.y1};
			n_cut = '{p_q.x0, p_q.y0, x.x0, p_q.y1}; cut_ok = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ext_q   <= '0;
			wcnt_q  <= '0;
			wj_q    <= '0;
			i_q     <= '0;
			st_q    <= '0;
			keep_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ext_q   <= ext_d;
			wcnt_q  <= wcnt_d;
			wj_q    <= wj_d;
			i_q     <= i_d;
			st_q    <= st_d;
			keep_q  <= keep_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		p_q    <= p_d;
		rd_q   <= rd_d;
		hole_q <= hole_d;
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ext_d   = ext_q;
		wcnt_d  = wcnt_q;
		wj_d    = wj_q;
		i_d     = i_q;
		p_d     = p_q;
		rd_d    = rd_q;
		st_d    = st_q;
		hole_d  = hole_q;
		keep_d  = keep_q;
		done_d  = 1'b0;
		t_we    = 1'b0;
		t_waddr = i_q[IW-1:0];
		t_wdata = p_q;
		t_raddr = i_q[IW-1:0];
		w_we    = 1'b0;
		w_waddr = wcnt_q[WI-1:0];
		w_wdata = o_cut;
		w_raddr = wj_q[WI-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					st_d = ST_DONE;
					rd_d = '0;
					t_raddr = entry_index;
					hole_d = entry_index;
					unique case (kind_t'(kind))
						KIND_UNION: begin
							if (!in_ok) begin
								st_d = ST_REJECT;
								state_d = S_DONE;
							end else begin
								ext_d = f_grow(ext_q, clipped);
								w_we = 1'b1;
								w_waddr = '0;
								w_wdata = clipped;
								wcnt_d = WC'(1);
								wj_d = '0;
								state_d = S_PIECE_RD;
							end
						end
						KIND_READ: begin
							if ({1'b0, entry_index} < cnt_q) state_d = S_READ_WAIT;
							else begin
								st_d = ST_REJECT;
								state_d = S_DONE;
							end
						end
						KIND_REMOVE: begin
							if ({1'b0, entry_index} < cnt_q) state_d = S_REMOVE_RD;
							else begin
								st_d = ST_REJECT;
								state_d = S_DONE;
							end
						end
						KIND_CLEAR: begin
							cnt_d = '0;
							ext_d = '0;
							state_d = S_DONE;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_READ_WAIT: begin
				t_raddr = hole_q;
				state_d = S_READ_DONE;
			end
			S_READ_DONE: begin
				rd_d = t_rdata;
				state_d = S_DONE;
			end
			S_REMOVE_RD: begin
				t_raddr = IW'(cnt_q - CW'(1));
				state_d = S_REMOVE_WAIT;
			end
			S_REMOVE_WAIT: begin
				t_raddr = IW'(cnt_q - CW'(1));
				state_d = S_DROP_WR;
			end
			S_PIECE_RD: state_d = S_PIECE_WAIT;
			S_PIECE_WAIT: begin
				p_d = w_rdata;
				i_d = '0;
				keep_d = 1'b1;
				state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				if (i_q < cnt_q) state_d = S_SCAN_WAIT;
				else state_d = S_KEEP;
			end
			S_SCAN_WAIT: state_d = S_SCAN_EVAL;
			S_SCAN_EVAL: begin
				state_d = S_SCAN_RD;
				hole_d = i_q[IW-1:0];
				if (!f_touch(e, p_q)) begin
					i_d = i_q + CW'(1);
				end else if (f_within(p_q, e)) begin
					keep_d = 1'b0;
					state_d = S_KEEP;
				end else if (f_within(e, p_q)) begin
					state_d = S_DROP_RD;
				end else if ((e.y0 == p_q.y0 && e.y1 == p_q.y1)
						|| (e.x0 == p_q.x0 && e.x1 == p_q.x1)) begin
					p_d = f_grow(p_q, e);
					state_d = S_DROP_RD;
				end else if (!f_over(e, p_q)) begin
					i_d = i_q + CW'(1);
				end else if (ep[RW]) begin
					p_d = ep[RW-1:0];
					i_d = i_q + CW'(1);
				end else if (ee[RW]) begin
					t_we = 1'b1;
					t_wdata = ee[RW-1:0];
					i_d = i_q + CW'(1);
				end else if (cut_ok) begin
					p_d = n_cut;
					if (wcnt_q < WC'(WORK_DEPTH)) begin
						w_we = 1'b1;
						wcnt_d = wcnt_q + WC'(1);
					end else if (st_q == ST_DONE) begin
						st_d = ST_OVERFLOW;
					end
					i_d = i_q + CW'(1);
				end else begin
					if (st_q == ST_DONE) st_d = ST_UNCUT;
					keep_d = 1'b0;
					state_d = S_KEEP;
				end
			end
			S_DROP_RD: begin
				t_raddr = IW'(cnt_q - CW'(1));
				state_d = S_DROP_WAIT;
			end
			S_DROP_WAIT: begin
				t_raddr = IW'(cnt_q - CW'(1));
				state_d = S_DROP_WR;
			end
			S_DROP_WR: begin
				t_we = 1'b1;
				t_waddr = hole_q;
				t_wdata = t_rdata;
				cnt_d = cnt_q - CW'(1);
				state_d = (wcnt_q == '0) ? S_DONE : S_SCAN_RD;
			end
			S_KEEP: begin
				if (keep_q) begin
					if (cnt_q < CW'(MAX_RECTS)) begin
						t_we = 1'b1;
						t_waddr = cnt_q[IW-1:0];
						t_wdata = p_q;
						cnt_d = cnt_q + CW'(1);
					end else if (st_q == ST_DONE) begin
						st_d = ST_OVERFLOW;
					end
				end
				state_d = S_NEXT_PIECE;
			end
			S_NEXT_PIECE: begin
				if (wj_q + WC'(1) < wcnt_q) begin
					wj_d = wj_q + WC'(1);
					state_d = S_PIECE_RD;
				end else begin
					wcnt_d = '0;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				done_d = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = st_q;
	assign rect_count  = cnt_q;
	assign entry_min_x = rd_q.x0;
	assign entry_min_y = rd_q.y0;
	assign entry_max_x = rd_q.x1;
	assign entry_max_y = rd_q.y1;
	assign bound_min_x = ext_q.x0;
	assign bound_min_y = ext_q.y0;
	assign bound_max_x = ext_q.x1;
	assign bound_max_y = ext_q.y1;

endmodule
`default_nettype wire

// File: hdl/drru_ram.sv
`default_nettype none
module drru_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: hdl/drru_checker.sv
`default_nettype none
module drru_props #(
	parameter int MAX_RECTS = 64
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic                         done,
	input wire logic [$clog2(MAX_RECTS+1)-1:0] rect_count
);

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without request");

	a_request_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request not taken");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy after done");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rect_count <= ($clog2(MAX_RECTS+1))'(MAX_RECTS)) else $error("count overflow");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !$past(busy) |-> $stable(rect_count)) else $error("count moved idle");

endmodule

bind dirty_rectangle_region_union_core drru_props #(.MAX_RECTS(MAX_RECTS)) u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.rect_count(rect_count)
);
`default_nettype wire
